/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lcta_pkg.sv */
// Shared constants, types and helpers of the load-cell trimmed average block.
`timescale 1ns / 1ps
package lcta_pkg;
    localparam int LCTA_DEPTH = 16;
    localparam int WORD_W     = 24;
    localparam int WEIGHT_W   = 32;
    localparam int SCALE_W    = 32;
    localparam int ACTION_W   = 2;
    localparam int FRAC_W     = 24;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'h0100_0000;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TARE = 2'd2;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic signed [WEIGHT_W-1:0] f_sat32(input logic signed [WEIGHT_W:0] v);
        logic signed [WEIGHT_W-1:0] res;
        if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
            res = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            res = v[WEIGHT_W-1:0];
        end
        return res;
    endfunction
endpackage

/* rtl/lcta_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lcta_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/lcta_div.sv */
// Divider by a constant: reciprocal multiply, quotient registered in the cycle after the dividend is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcta_div import lcta_pkg::*; #(
    parameter int DIVIDEND_W = 29,
    parameter int DIVISOR    = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctl              i_ctl,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output t_div_sts              o_sts,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    // exact for every dividend below 2^DIVIDEND_W
    localparam int SH = DIVIDEND_W + $clog2(DIVISOR);
    localparam int MW = DIVIDEND_W + 1;
    localparam int PW = SH + DIVIDEND_W;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << SH) + longint'(DIVISOR - 1)) / longint'(DIVISOR));

    logic                  r_busy, r_done;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [PW-1:0]         r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= !r_busy && i_ctl.start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_ctl.start) begin
            r_dvd <= i_dividend;
        end
        if (r_busy) begin
            r_prod <= PW'(r_dvd) * PW'(RECIP);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_prod[PW-1:SH];

    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_ctl.start && !r_busy, r_busy)
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `ASSERT_IMPL(a_quo_bound, i_clk, i_rst_n, r_done, o_quotient <= r_dvd)
endmodule

/* rtl/load_cell_trimmed_average_top.sv */
// Load-cell trimmed moving average: top level.
// Each request pushes a sample, reads the weight, or tares; every request gives one result.
// The ring is walked one entry a cycle through the read port of the sample RAM into one
// compare-and-add unit, then the trimmed sum is divided by DEPTH-2 with a reciprocal
// multiply, followed by a 24x32 multiply, scaling and tare subtraction. The next request is
// taken once the result is loaded into the output register, even while that result still
// waits on the output; a result still held there stalls the block in its last step.
// Entries not yet written since reset read as zero. The scale register may be written at
// any time the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module load_cell_trimmed_average_top import lcta_pkg::*; #(
    parameter int DEPTH = LCTA_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [SCALE_W-1:0]         i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic [WORD_W-1:0]          i_raw_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [WEIGHT_W-1:0] o_weight,
    output logic signed [WORD_W-1:0]   o_trimmed_mean,
    output logic signed [WORD_W-1:0]   o_latest_sample
);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SUM_W  = WORD_W + IDX_W + 1;
    localparam int PROD_W = WORD_W + SCALE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_TRIM = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SCL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]                 r_state;
    logic [SCALE_W-1:0]         r_scale;
    logic [IDX_W-1:0]           r_idx;
    logic [DEPTH-1:0]           r_vld;
    logic signed [WEIGHT_W-1:0] r_tare;
    logic [ACTION_W-1:0]        r_action;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_rd_vld;
    logic                       r_rd_ent;
    logic [IDX_W-1:0]           r_rd_addr;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [WORD_W-1:0]   r_lo, r_hi, r_latest, r_mean;
    logic                       r_neg;
    logic [WORD_W-1:0]          r_mag;
    logic [PROD_W-1:0]          r_prod;
    logic signed [WEIGHT_W-1:0] r_scaled;
    logic                       r_out_valid;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic signed [WORD_W-1:0]   r_out_mean, r_out_latest;

    logic                       in_acc, do_push, rd_issue, out_load;
    logic [IDX_W-1:0]           idx_next;
    logic [WORD_W-1:0]          rdata;
    logic signed [WORD_W-1:0]   smp;
    logic signed [SUM_W-1:0]    trimmed;
    logic [SUM_W-1:0]           tmag;
    logic [SUM_W-1:0]           quo;
    logic [WORD_W-1:0]          qmag;
    logic [PROD_W:0]            prod_rnd;
    logic signed [WEIGHT_W:0]   scl_pos, scl_neg;
    logic signed [WEIGHT_W-1:0] tare_eff;
    logic signed [WEIGHT_W:0]   diff;
    t_div_ctl                   div_ctl;
    t_div_sts                   div_sts;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign do_push     = in_acc && (i_action == ACT_PUSH);
    assign idx_next    = (r_idx == IDX_W'(DEPTH - 1)) ? '0 : r_idx + IDX_W'(1);
    assign rd_issue    = (r_state == S_ACC) && (r_cnt < CNT_W'(DEPTH));
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    lcta_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (idx_next),
        .i_wdata (i_raw_word),
        .i_re    (rd_issue),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign smp     = r_rd_ent ? $signed(rdata) : '0;
    assign trimmed = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);
    assign tmag    = trimmed[SUM_W-1] ? SUM_W'(-trimmed) : SUM_W'(trimmed);
    assign qmag    = quo[WORD_W-1:0];

    assign div_ctl.start = (r_state == S_TRIM);

    lcta_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (DEPTH - 2)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (tmag),
        .o_sts      (div_sts),
        .o_quotient (quo)
    );

    assign prod_rnd = {1'b0, r_prod} + (PROD_W + 1)'({FRAC_W{1'b1}});
    assign scl_pos  = $signed({1'b0, r_prod[PROD_W-1:FRAC_W]});
    assign scl_neg  = -$signed({1'b0, prod_rnd[PROD_W-1:FRAC_W]});
    assign tare_eff = (r_action == ACT_TARE) ? r_scaled : r_tare;
    assign diff     = (WEIGHT_W + 1)'(r_scaled) - (WEIGHT_W + 1)'(tare_eff);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= SCALE_RST;
            r_idx       <= '0;
            r_vld       <= '0;
            r_tare      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (do_push) begin
                r_idx           <= idx_next;
                r_vld[idx_next] <= 1'b1;
            end
            r_rd_vld <= rd_issue;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_cnt == CNT_W'(DEPTH) && !r_rd_vld) r_state <= S_TRIM;
                end
                S_TRIM: r_state <= S_DIV;
                S_DIV: begin
                    if (div_sts.done) r_state <= S_MUL;
                end
                S_MUL: r_state <= S_SCL;
                S_SCL: r_state <= S_FIN;
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                        r_tare  <= tare_eff;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_lo     <= 24'sh7F_FFFF;
            r_hi     <= -24'sh80_0000;
        end
        if (rd_issue) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        r_rd_addr <= r_cnt[IDX_W-1:0];
        r_rd_ent  <= r_vld[r_cnt[IDX_W-1:0]];
        if (r_rd_vld) begin
            r_sum <= r_sum + SUM_W'(smp);
            if (smp < r_lo) r_lo <= smp;
            if (smp > r_hi) r_hi <= smp;
            if (r_rd_addr == r_idx) r_latest <= smp;
        end
        if (r_state == S_TRIM) begin
            r_neg <= trimmed[SUM_W-1];
        end
        if (r_state == S_DIV && div_sts.done) begin
            r_mag  <= qmag;
            r_mean <= r_neg ? -$signed(qmag) : $signed(qmag);
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(r_scale);
        end
        if (r_state == S_SCL) begin
            r_scaled <= f_sat32(r_neg ? scl_neg : scl_pos);
        end
        if (out_load) begin
            r_weight     <= f_sat32(diff);
            r_out_mean   <= r_mean;
            r_out_latest <= r_latest;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_weight        = r_weight;
    assign o_trimmed_mean  = r_out_mean;
    assign o_latest_sample = r_out_latest;

    `ASSERT_IMPL(a_rd_in_acc, i_clk, i_rst_n, r_rd_vld, r_state == S_ACC)
    `ASSERT_NEXT(a_tare_zero, i_clk, i_rst_n, out_load && r_action == ACT_TARE, o_weight == '0)
    `ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, out_load, o_out_valid && r_state == S_IDLE)
endmodule
